// ===== hw/rtl/chs_pkg.sv =====
`timescale 1ns / 1ps

package chs_pkg;

    // fixed field widths
    localparam int CFG_W      = 5;
    localparam int STATUS_W   = 2;
    localparam int BUCKET_W   = 4;
    localparam int REM_W      = CFG_W;
    localparam int DIGIT_BITS = 4;

    localparam logic [CFG_W-1:0] RESET_BUCKETS = 5'd10;

    // command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_INSERTED  = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FOUND     = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_POOL_FULL = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_DECIDE,
        ST_LINK,
        ST_WALK
    } chs_state_t;

    // modulo unit controls
    typedef struct packed {
        logic load;
        logic step;
    } chs_mod_ctl_t;

    // node store write controls
    typedef struct packed {
        logic wr_key;
        logic wr_link;
    } chs_node_ctl_t;

endpackage

// ===== hw/rtl/chs_mod_unit.sv =====
`timescale 1ns / 1ps

module chs_mod_unit
    import chs_pkg::*;
#(
    parameter int KEY_BITS = 31
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  chs_mod_ctl_t        ctl,
    input  logic [KEY_BITS-1:0] key,
    input  logic [CFG_W-1:0]    divisor,
    output logic                done,
    output logic [REM_W-1:0]    rem
);

    localparam int STEPS = (KEY_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int PAD_W = STEPS * DIGIT_BITS;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [PAD_W-1:0] shift_reg, shift_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [CFG_W-1:0] div_reg, div_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign done = (cnt_reg == CNT_W'(STEPS));
    assign rem  = rem_reg;

    // restoring remainder, one digit of key bits per step
    always_comb
    begin
        logic [REM_W:0]   trial;
        logic [REM_W-1:0] r;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        cnt_next   = cnt_reg;
        r          = rem_reg;
        trial      = '0;
        if (ctl.load)
        begin
            shift_next = PAD_W'(key);
            rem_next   = '0;
            div_next   = divisor;
            cnt_next   = '0;
        end
        else if (ctl.step && !done)
        begin
            for (int i = 0; i < DIGIT_BITS; i++)
            begin
                trial = {r, shift_reg[PAD_W-1-i]};
                if (trial >= {1'b0, div_reg})
                begin
                    trial = trial - {1'b0, div_reg};
                end
                r = trial[REM_W-1:0];
            end
            rem_next   = r;
            shift_next = shift_reg << DIGIT_BITS;
            cnt_next   = cnt_reg + CNT_W'(1);
        end
    end

    // step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= CNT_W'(STEPS);
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        div_reg   <= div_next;
    end

endmodule

// ===== hw/rtl/chs_node_mem.sv =====
`timescale 1ns / 1ps

module chs_node_mem
    import chs_pkg::*;
#(
    parameter int POOL_SIZE = 256,
    parameter int KEY_BITS  = 31,
    parameter int NODE_W    = 8
)
(
    input  logic                clk,
    input  chs_node_ctl_t       ctl,
    input  logic [NODE_W-1:0]   wr_addr,
    input  logic [KEY_BITS-1:0] wr_key,
    input  logic [NODE_W:0]     wr_link,
    input  logic [NODE_W-1:0]   rd_addr,
    output logic [KEY_BITS-1:0] rd_key,
    output logic [NODE_W:0]     rd_link
);

    logic [KEY_BITS-1:0] key_mem [POOL_SIZE];
    logic [NODE_W:0]     link_mem [POOL_SIZE];
    logic [KEY_BITS-1:0] rd_key_reg;
    logic [NODE_W:0]     rd_link_reg;

    assign rd_key  = rd_key_reg;
    assign rd_link = rd_link_reg;

    // key store
    always_ff @(posedge clk)
    begin
        if (ctl.wr_key)
        begin
            key_mem[wr_addr] <= wr_key;
        end
        rd_key_reg <= key_mem[rd_addr];
    end

    // link store, msb marks end of chain
    always_ff @(posedge clk)
    begin
        if (ctl.wr_link)
        begin
            link_mem[wr_addr] <= wr_link;
        end
        rd_link_reg <= link_mem[rd_addr];
    end

endmodule

// ===== hw/rtl/chained_hash_set_top.sv =====
`timescale 1ns / 1ps

// Hash set of keys with separate chaining over a bump-allocated node pool.
// Request channel: drive cmd (0 insert, 1 search) and key with start high;
// the request is taken at a clock edge where start is high and busy is low.
// Every request yields one result: done is high for exactly one cycle with
// status (0 inserted, 1 found, 2 not found, 3 pool full) and bucket.
// The receiver cannot stall; a result is gone after its done cycle.
// The shared 4-bit-per-cycle remainder unit first reduces the key to a
// bucket; the sequencer then decides. An insert into an empty bucket, a
// pool-full insert and a search of an empty bucket end there. An insert
// into a non-empty bucket then links the old tail to the new node, and a
// search walks the chain through the node store read port, one visited
// node at a time. busy is low in the done cycle, so a new request may be
// taken there; one request is in work at a time. The user must write the
// bucket_count register (cfg_we, cfg_data) only while idle; the block does
// not enforce it. Reset empties every bucket, frees the pool and loads
// bucket_count with 10; no clearing pass is needed.
module chained_hash_set_top
    import chs_pkg::*;
#(
    parameter int MAX_BUCKETS = 16,
    parameter int POOL_SIZE   = 256,
    parameter int KEY_BITS    = 31
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic                start,
    output logic                busy,
    input  logic                cmd,
    input  logic [KEY_BITS-1:0] key,
    output logic                done,
    output logic [STATUS_W-1:0] status,
    output logic [BUCKET_W-1:0] bucket
);

    localparam int NODE_W = $clog2(POOL_SIZE);
    localparam int USED_W = $clog2(POOL_SIZE + 1);
    localparam int BKT_W  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int CAP_I  = (MAX_BUCKETS > 31) ? 31 : MAX_BUCKETS;
    localparam logic [CFG_W-1:0] DIV_CAP = CFG_W'(CAP_I);

    chs_state_t state_reg, state_next;

    logic [CFG_W-1:0]    bucket_count_reg;
    logic [CFG_W-1:0]    eff_div;
    logic                cmd_reg, cmd_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [USED_W-1:0]   used_reg, used_next;
    logic [USED_W-1:0]   steps_reg, steps_next;
    logic [NODE_W-1:0]   tail_reg, tail_next;
    logic [NODE_W-1:0]   node_reg, node_next;
    logic                done_reg, done_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [BUCKET_W-1:0] bucket_reg, bucket_next;

    logic [MAX_BUCKETS-1:0] bkt_valid_reg, bkt_valid_next;
    logic [2*NODE_W-1:0]    bkt_mem [MAX_BUCKETS];
    logic [2*NODE_W-1:0]    bkt_rdata_reg;
    logic [2*NODE_W-1:0]    bkt_wdata;
    logic                   bkt_we;
    logic [BKT_W-1:0]       bkt_idx;
    logic [NODE_W-1:0]      bkt_head;
    logic [NODE_W-1:0]      bkt_tail;

    chs_mod_ctl_t      mod_ctl;
    logic              mod_done;
    logic [REM_W-1:0]  mod_rem;

    chs_node_ctl_t       node_ctl;
    logic [NODE_W-1:0]   node_wr_addr;
    logic [NODE_W:0]     node_wr_link;
    logic [NODE_W-1:0]   node_rd_addr;
    logic [KEY_BITS-1:0] node_rd_key;
    logic [NODE_W:0]     node_rd_link;
    logic [USED_W-1:0]   steps_inc;

    // effective divisor: zero acts as one, large values saturate
    always_comb
    begin
        if (bucket_count_reg == '0)
        begin
            eff_div = CFG_W'(1);
        end
        else if (bucket_count_reg > DIV_CAP)
        begin
            eff_div = DIV_CAP;
        end
        else
        begin
            eff_div = bucket_count_reg;
        end
    end

    chs_mod_unit #(
        .KEY_BITS (KEY_BITS)
    ) u_mod (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mod_ctl),
        .key     (key),
        .divisor (eff_div),
        .done    (mod_done),
        .rem     (mod_rem)
    );

    chs_node_mem #(
        .POOL_SIZE (POOL_SIZE),
        .KEY_BITS  (KEY_BITS),
        .NODE_W    (NODE_W)
    ) u_nodes (
        .clk     (clk),
        .ctl     (node_ctl),
        .wr_addr (node_wr_addr),
        .wr_key  (key_reg),
        .wr_link (node_wr_link),
        .rd_addr (node_rd_addr),
        .rd_key  (node_rd_key),
        .rd_link (node_rd_link)
    );

    assign bkt_idx   = BKT_W'(mod_rem);
    assign bkt_head  = bkt_rdata_reg[2*NODE_W-1:NODE_W];
    assign bkt_tail  = bkt_rdata_reg[NODE_W-1:0];
    assign steps_inc = steps_reg + USED_W'(1);

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign status = status_reg;
    assign bucket = bucket_reg;

    // bucket head/tail table
    always_ff @(posedge clk)
    begin
        if (bkt_we)
        begin
            bkt_mem[bkt_idx] <= bkt_wdata;
        end
        bkt_rdata_reg <= bkt_mem[bkt_idx];
    end

    // state register and control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            bucket_count_reg <= RESET_BUCKETS;
            used_reg         <= '0;
            bkt_valid_reg    <= '0;
            done_reg         <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            bkt_valid_reg <= bkt_valid_next;
            done_reg      <= done_next;
            if (cfg_we)
            begin
                bucket_count_reg <= cfg_data;
            end
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        key_reg    <= key_next;
        steps_reg  <= steps_next;
        tail_reg   <= tail_next;
        node_reg   <= node_next;
        status_reg <= status_next;
        bucket_reg <= bucket_next;
    end

    // sequencer: next state and outputs
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        used_next      = used_reg;
        steps_next     = steps_reg;
        tail_next      = tail_reg;
        node_next      = node_reg;
        bkt_valid_next = bkt_valid_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        bucket_next    = bucket_reg;
        mod_ctl        = '0;
        node_ctl       = '0;
        node_wr_addr   = used_reg[NODE_W-1:0];
        node_wr_link   = {1'b1, NODE_W'(0)};
        node_rd_addr   = node_rd_link[NODE_W-1:0];
        bkt_we         = 1'b0;
        bkt_wdata      = {bkt_head, used_reg[NODE_W-1:0]};

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next     = cmd;
                    key_next     = key;
                    mod_ctl.load = 1'b1;
                    state_next   = ST_MOD;
                end
            end

            ST_MOD:
            begin
                mod_ctl.step = 1'b1;
                if (mod_done)
                begin
                    bucket_next = mod_rem[BUCKET_W-1:0];
                    state_next  = ST_DECIDE;
                end
            end

            ST_DECIDE:
            begin
                if (cmd_reg == CMD_INSERT)
                begin
                    if (used_reg >= USED_W'(POOL_SIZE))
                    begin
                        status_next = STAT_POOL_FULL;
                        done_next   = 1'b1;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        // new node at the end of the chain
                        node_ctl.wr_key  = 1'b1;
                        node_ctl.wr_link = 1'b1;
                        bkt_we           = 1'b1;
                        node_next        = used_reg[NODE_W-1:0];
                        used_next        = used_reg + USED_W'(1);
                        bkt_valid_next[bkt_idx] = 1'b1;
                        if (bkt_valid_reg[bkt_idx])
                        begin
                            tail_next  = bkt_tail;
                            state_next = ST_LINK;
                        end
                        else
                        begin
                            bkt_wdata   = {used_reg[NODE_W-1:0], used_reg[NODE_W-1:0]};
                            status_next = STAT_INSERTED;
                            done_next   = 1'b1;
                            state_next  = ST_IDLE;
                        end
                    end
                end
                else
                begin
                    if (bkt_valid_reg[bkt_idx])
                    begin
                        node_rd_addr = bkt_head;
                        steps_next   = '0;
                        state_next   = ST_WALK;
                    end
                    else
                    begin
                        status_next = STAT_NOT_FOUND;
                        done_next   = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
            end

            ST_LINK:
            begin
                // old tail points at the new node
                node_ctl.wr_link = 1'b1;
                node_wr_addr     = tail_reg;
                node_wr_link     = {1'b0, node_reg};
                status_next      = STAT_INSERTED;
                done_next        = 1'b1;
                state_next       = ST_IDLE;
            end

            ST_WALK:
            begin
                // one node compared per cycle, next read follows the link
                if (node_rd_key == key_reg)
                begin
                    status_next = STAT_FOUND;
                    done_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
                else if (node_rd_link[NODE_W] || (steps_inc >= used_reg))
                begin
                    status_next = STAT_NOT_FOUND;
                    done_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    node_rd_addr = node_rd_link[NODE_W-1:0];
                    steps_next   = steps_inc;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // pool fill never passes the pool size
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= USED_W'(POOL_SIZE))
        else $error("node pool count out of range");

    // a result is shown only once the sequencer is back at idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == ST_IDLE))
        else $error("result strobe while busy");

    // the pool grows only with an inserted result
    a_used_grow: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(used_reg) |-> ((cmd_reg == CMD_INSERT)
            && ((state_reg == ST_LINK) || (done_reg && (status_reg == STAT_INSERTED)))))
        else $error("pool count changed without an insert");

    // a search never reports an insert outcome
    a_search_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (cmd_reg == CMD_SEARCH))
            |-> ((status_reg == STAT_FOUND) || (status_reg == STAT_NOT_FOUND)))
        else $error("search gave an insert status");

    // a request is taken only from idle and starts the remainder unit
    a_start_mod: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == ST_MOD))
        else $error("request not started");

endmodule
